/* src/ptlos_pkg.sv */
`timescale 1ns / 1ps
package ptlos_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_FIND    = 3'd2,
    OP_CHK     = 3'd3,
    OP_REF     = 3'd4,
    OP_ADJ_ALL = 3'd5,
    OP_ADJ_LIM = 3'd6,
    OP_SET     = 3'd7
  } op_t;

  typedef enum logic {
    CFG_LAST_INDEX = 1'b0,
    CFG_ALLOW_DUP  = 1'b1
  } cfg_idx_t;

endpackage

/* src/ptlos_if.sv */
`timescale 1ns / 1ps
interface pos_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic        [10:0] entry_index;
  logic signed [31:0] position;
  logic signed [31:0] offset_delta;

  modport source (output valid, opcode, entry_index, position, offset_delta, input ready);
  modport sink   (input valid, opcode, entry_index, position, offset_delta, output ready);
endinterface

interface pos_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] found_index;
  logic signed [31:0] position_out;

  modport source (output valid, found_index, position_out, input ready);
  modport sink   (input valid, found_index, position_out, output ready);
endinterface

/* src/ptlos_mem.sv */
`timescale 1ns / 1ps
module ptlos_mem #(
  parameter int unsigned DEPTH = ptlos_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [31:0]   wd,
  input  logic [AW-1:0] ra,
  output logic [31:0]   rd
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end
endmodule

/* src/position_table_lazy_offset_search.sv */
`timescale 1ns / 1ps
// Sorted table of signed 32-bit text positions held in one single-port-read,
// single-port-write synchronous RAM, with a pending offset that applies lazily
// to every entry at or above a start index. One request is worked at a time
// by a sequencer that issues RAM reads one at a time and uses each read's data
// in the state that follows. A find is a binary search (ten steps for 1024
// entries), then, when duplicates are allowed, a step back over equal
// neighbors; the checked and reference finds add two boundary reads, and the
// reference find a forward scan; the adjust operations read and rewrite each
// entry touched. A new request is taken while the previous result still waits
// in the output register. The table has no reset: an entry never written
// reads as anything.
module position_table_lazy_offset_search #(
  parameter int unsigned MAX_ENTRIES = ptlos_pkg::MAX_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_wdata,
  pos_req_if.sink    in_req,
  pos_rsp_if.source  out_rsp
);
  import ptlos_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = (AW + 1 > 12) ? AW + 1 : 12;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHK0, S_CHKL, S_REF0, S_REFL, S_SRCH, S_SCMP,
    S_DUP0, S_DUPC, S_HIT, S_SCAN, S_SCMP2, S_ADJ, S_ADJW, S_FIN
  } state_t;

  state_t      state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic [10:0] idx_r, idx_nxt;
  logic [31:0] cp_r, cp_nxt;
  logic [9:0]  last_index_r;
  logic        dup_r;
  logic [31:0] off_r, off_nxt;
  logic [10:0] ostart_r, ostart_nxt;
  logic [9:0]  hint_r, hint_nxt;
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [11:0] res_found_r, res_found_nxt;
  logic [31:0] res_pos_r, res_pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_found_r, out_found_nxt;
  logic [31:0] out_pos_r, out_pos_nxt;

  logic [AW-1:0] rd_addr, rd_addr_r, wa;
  logic [31:0]   rd_data, wd, eff, last_ext;
  logic          we, adj_go;
  logic [AW-1:0] last;
  logic [AW:0]   span;

  ptlos_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
    .clk(clk), .we(we), .wa(wa), .wd(wd), .ra(rd_addr), .rd(rd_data)
  );

  // Effective index of the last valid entry, clamped to the table.
  assign last_ext = (32'(last_index_r) > 32'(MAX_ENTRIES - 1)) ?
                    32'(MAX_ENTRIES - 1) : 32'(last_index_r);
  assign last     = last_ext[AW-1:0];

  // Effective value of the entry read in the previous cycle.
  assign eff = rd_data + ((CW'(rd_addr_r) >= CW'(ostart_r)) ? off_r : 32'd0);

  assign span = (AW+1)'(hi_r) - (AW+1)'(lo_r) + (AW+1)'(1);

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.found_index  = out_found_r;
  assign out_rsp.position_out = out_pos_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    cp_nxt        = cp_r;
    off_nxt       = off_r;
    ostart_nxt    = ostart_r;
    hint_nxt      = hint_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    rd_addr       = '0;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;
    adj_go        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt        = op_t'(in_req.opcode);
          idx_nxt       = in_req.entry_index;
          cp_nxt        = in_req.position;
          res_found_nxt = '0;
          res_pos_nxt   = '0;
          state_nxt     = S_FIN;
          unique case (op_t'(in_req.opcode))
            OP_READ: begin
              if (32'(in_req.entry_index) < 32'(MAX_ENTRIES)) begin
                rd_addr   = AW'(in_req.entry_index);
                state_nxt = S_READ;
              end
            end
            OP_WRITE: begin
              if (32'(in_req.entry_index) < 32'(MAX_ENTRIES)) begin
                we = 1'b1;
                wa = AW'(in_req.entry_index);
                wd = in_req.position -
                     ((in_req.entry_index >= ostart_r) ? off_r : 32'd0);
              end
            end
            OP_FIND: begin
              lo_nxt    = '0;
              hi_nxt    = last;
              state_nxt = S_SRCH;
            end
            OP_CHK: begin
              state_nxt = S_CHK0;
            end
            OP_REF: begin
              state_nxt = S_REF0;
            end
            OP_ADJ_ALL: begin
              if (off_r != 32'd0) begin
                cnt_nxt   = CW'(ostart_r);
                state_nxt = S_ADJ;
              end else begin
                ostart_nxt = '0;
              end
            end
            OP_ADJ_LIM: begin
              if (off_r != 32'd0) begin
                cnt_nxt   = CW'(ostart_r);
                state_nxt = S_ADJ;
              end
            end
            OP_SET: begin
              off_nxt    = in_req.offset_delta;
              ostart_nxt = in_req.entry_index;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_pos_nxt = eff;
        state_nxt   = S_FIN;
      end
      S_CHK0: begin
        // Entry 0 address was driven as zero by default in the previous cycle.
        if ($signed(cp_r) < $signed(eff)) begin
          res_found_nxt = '1;
          state_nxt     = S_FIN;
        end else begin
          rd_addr   = last;
          state_nxt = S_CHKL;
        end
      end
      S_CHKL: begin
        if (!($signed(cp_r) < $signed(eff))) begin
          res_found_nxt = '1;
          state_nxt     = S_FIN;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = last;
          state_nxt = S_SRCH;
        end
      end
      S_REF0: begin
        if (!($signed(eff) < $signed(cp_r))) begin
          res_found_nxt = '0;
          state_nxt     = S_FIN;
        end else begin
          rd_addr   = last;
          state_nxt = S_REFL;
        end
      end
      S_REFL: begin
        if ($signed(eff) < $signed(cp_r)) begin
          res_found_nxt = '1;
          state_nxt     = S_FIN;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = last;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          rd_addr   = lo_r + AW'(span >> 1);
          state_nxt = S_SCMP;
        end else if (dup_r && lo_r != '0) begin
          rd_addr   = lo_r;
          state_nxt = S_DUP0;
        end else begin
          state_nxt = S_HIT;
        end
      end
      S_SCMP: begin
        if (!($signed(cp_r) < $signed(eff))) begin
          lo_nxt = rd_addr_r;
        end else begin
          hi_nxt = rd_addr_r - AW'(1);
        end
        state_nxt = S_SRCH;
      end
      S_DUP0: begin
        cur_nxt   = eff;
        rd_addr   = lo_r - AW'(1);
        state_nxt = S_DUPC;
      end
      S_DUPC: begin
        // Step back while the lower neighbor holds the same position.
        if (eff == cur_r) begin
          lo_nxt = lo_r - AW'(1);
          if (lo_r != AW'(1)) begin
            rd_addr = lo_r - AW'(2);
          end else begin
            state_nxt = S_HIT;
          end
        end else begin
          state_nxt = S_HIT;
        end
      end
      S_HIT: begin
        hint_nxt = 10'(lo_r);
        if (op_r == OP_REF) begin
          cnt_nxt   = CW'(lo_r);
          state_nxt = S_SCAN;
        end else begin
          res_found_nxt = 12'(lo_r);
          state_nxt     = S_FIN;
        end
      end
      S_SCAN: begin
        if (cnt_r <= CW'(last)) begin
          rd_addr   = AW'(cnt_r);
          state_nxt = S_SCMP2;
        end else begin
          res_found_nxt = 12'(cnt_r);
          state_nxt     = S_FIN;
        end
      end
      S_SCMP2: begin
        if ($signed(eff) < $signed(cp_r)) begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_SCAN;
        end else begin
          res_found_nxt = 12'(cnt_r);
          state_nxt     = S_FIN;
        end
      end
      S_ADJ: begin
        if (op_r == OP_ADJ_ALL) begin
          adj_go = (cnt_r <= CW'(last));
        end else begin
          adj_go = (cnt_r < CW'(idx_r)) && (32'(cnt_r) < 32'(MAX_ENTRIES));
        end
        if (adj_go) begin
          rd_addr   = AW'(cnt_r);
          state_nxt = S_ADJW;
        end else begin
          state_nxt = S_FIN;
          if (op_r == OP_ADJ_ALL) begin
            off_nxt    = '0;
            ostart_nxt = '0;
          end else if (CW'(idx_r) == CW'(last) + CW'(1)) begin
            off_nxt    = '0;
            ostart_nxt = '0;
          end else begin
            ostart_nxt = idx_r;
          end
        end
      end
      S_ADJW: begin
        // Fold the offset into the raw entry read in the previous cycle.
        we        = 1'b1;
        wa        = rd_addr_r;
        wd        = rd_data + off_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_ADJ;
      end
      S_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      off_r        <= '0;
      ostart_r     <= '0;
      hint_r       <= '0;
      last_index_r <= '0;
      dup_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      off_r       <= off_nxt;
      ostart_r    <= ostart_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LAST_INDEX: last_index_r <= cfg_wdata;
          CFG_ALLOW_DUP:  dup_r        <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    cp_r        <= cp_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    cur_r       <= cur_nxt;
    cnt_r       <= cnt_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    rd_addr_r   <= rd_addr;
  end

`ifndef NO_ASSERTIONS
  // The search window never inverts while a binary search is running.
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH |-> lo_r <= hi_r)
    else $error("search window inverted");

  // The hint only moves at the end of a search.
  a_hint: assert property (@(posedge clk) disable iff (!rst_n)
    hint_r != $past(hint_r) |-> $past(state_r) == S_HIT)
    else $error("search hint changed outside a search");

  // A set offset request takes its start index.
  a_set: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && in_req.valid && in_req.opcode == OP_SET
      |=> ostart_r == $past(in_req.entry_index))
    else $error("offset start not taken");
`endif
endmodule

/* tb/sv/position_table_lazy_offset_search_tb.sv */
`timescale 1ns / 1ps
module position_table_lazy_offset_search_tb;
  import ptlos_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam logic [31:0] POS_MIN = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [11:0] NOT_FOUND = 12'hfff;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [9:0] cfg_wdata;

  pos_req_if in_req();
  pos_rsp_if out_rsp();

  position_table_lazy_offset_search dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_req(in_req),
    .out_rsp(out_rsp)
  );

  // One request as the sender sees it.
  typedef struct {
    op_t         op;
    logic [10:0] idx;
    logic [31:0] pos;
    logic [31:0] delta;
  } request_t;

  // One expected response.
  typedef struct {
    logic [11:0] found;
    logic [31:0] pos;
  } answer_t;

  // A directed row. Where known is set, the answer is typed in and used as is;
  // otherwise the shadow table supplies it.
  typedef struct {
    op_t         op;
    logic [10:0] idx;
    logic [31:0] pos;
    logic [31:0] delta;
    bit          known;
    logic [11:0] found;
    logic [31:0] pos_out;
  } directed_row_t;

  // Shadow copy of the table and its lazy offset.
  logic [31:0] shadow_pos[DEPTH];
  bit          shadow_written[DEPTH];
  logic [31:0] shadow_offset;
  logic [10:0] shadow_start;
  logic [9:0]  shadow_hint;
  logic [9:0]  shadow_last;
  bit          shadow_dup;

  answer_t answers_due[$];
  int      errors;
  bit      no_idle;
  bit      stimulus_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run must finish well inside this window even when every request is a
  // full adjust over the largest table and both sides stall as long as they can.
  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

  // Effective position of an entry: the stored value plus the pending offset
  // when the entry lies at or above the offset start.
  function automatic logic [31:0] effective(int unsigned i);
    if (i >= DEPTH) return 32'd0;
    return shadow_pos[i] + ((i < shadow_start) ? 32'd0 : shadow_offset);
  endfunction

  function automatic bit below(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Binary search for the last entry at or below the position, then a step back
  // over equal neighbors when duplicates are allowed. Records the hint.
  function automatic int unsigned last_at_or_below(logic [31:0] cp);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = shadow_last;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (!below(cp, effective(mid))) lo = mid;
      else hi = mid - 1;
    end
    if (shadow_dup) begin
      while (lo > 0 && effective(lo - 1) == effective(lo)) lo--;
    end
    shadow_hint = lo[9:0];
    return lo;
  endfunction

  // Applies one accepted request to the shadow state and returns its answer.
  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int unsigned f;
    int unsigned i;
    int unsigned last;
    a.found = '0;
    a.pos = '0;
    last = shadow_last;
    case (r.op)
      OP_READ: a.pos = effective(r.idx);
      OP_WRITE: begin
        if (r.idx < DEPTH) begin
          shadow_pos[r.idx] = r.pos - ((r.idx < shadow_start) ? 32'd0 : shadow_offset);
          shadow_written[r.idx] = 1'b1;
        end
      end
      OP_FIND: a.found = 12'(last_at_or_below(r.pos));
      OP_CHK: begin
        if (below(r.pos, effective(0)) || !below(r.pos, effective(last))) a.found = NOT_FOUND;
        else a.found = 12'(last_at_or_below(r.pos));
      end
      OP_REF: begin
        if (!below(effective(0), r.pos)) begin
          a.found = '0;
        end else if (below(effective(last), r.pos)) begin
          a.found = NOT_FOUND;
        end else begin
          f = last_at_or_below(r.pos);
          while (f <= last && below(effective(f), r.pos)) f++;
          a.found = 12'(f);
        end
      end
      OP_ADJ_ALL: begin
        if (shadow_offset != 0) begin
          for (i = shadow_start; i <= last; i++) shadow_pos[i] += shadow_offset;
        end
        shadow_offset = '0;
        shadow_start = '0;
      end
      OP_ADJ_LIM: begin
        if (shadow_offset != 0) begin
          for (i = shadow_start; i < r.idx && i < DEPTH; i++) shadow_pos[i] += shadow_offset;
          shadow_start = r.idx;
          if (r.idx == last + 1) begin
            shadow_offset = '0;
            shadow_start = '0;
          end
        end
      end
      default: begin
        shadow_offset = r.delta;
        shadow_start = r.idx;
      end
    endcase
    return a;
  endfunction

  function automatic bit all_written(int unsigned lo, int unsigned hi);
    for (int unsigned i = lo; i <= hi && i < DEPTH; i++) begin
      if (!shadow_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, $signed(got), $signed(want),
             $realtime);
    errors++;
  endtask

  // Writes one register, then lowers the enable and waits before returning, so
  // that back-to-back writes never collide on the enable.
  task automatic write_register(cfg_idx_t which, logic [9:0] value);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_LAST_INDEX) shadow_last = value;
    else shadow_dup = value[0];
    @(posedge clk);
  endtask

  // Offers one request after a random gap and waits for the handshake. Valid
  // is left high on acceptance, so back-to-back requests never drop it; the
  // next call lowers it only when it actually idles. When typed_in is set, the
  // given answer is queued in place of the shadow one.
  task automatic send_request(request_t r, bit typed_in, answer_t typed);
    int unsigned gap;
    answer_t a;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.opcode <= r.op;
    in_req.entry_index <= r.idx;
    in_req.position <= r.pos;
    in_req.offset_delta <= r.delta;
    do @(posedge clk); while (!in_req.ready);
    a = apply_request(r);
    answers_due.push_back(typed_in ? typed : a);
  endtask

  task automatic wait_until_drained();
    in_req.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Fills entries 0..last in rising order, with runs of equal values when
  // duplicates are wanted and a little out-of-order noise now and then.
  task automatic fill_table(int unsigned last, bit dups);
    request_t r;
    answer_t none;
    logic [31:0] v;
    none = '{default: '0};
    v = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
    for (int unsigned i = 0; i <= last; i++) begin
      r.op = OP_WRITE;
      r.idx = 11'(i);
      r.delta = $urandom;
      r.pos = ($urandom_range(0, 19) == 0) ? 32'($urandom) : v;
      v += dups ? $urandom_range(0, 2) : $urandom_range(1, 1000);
      send_request(r, 1'b0, none);
    end
  endtask

  // Draws one random request that never touches an entry that was never
  // written. A position to search for usually lands on or next to an entry.
  function automatic request_t random_request();
    request_t r;
    int unsigned last;
    int unsigned pick;
    int unsigned end_at;
    last = shadow_last;
    r.idx = 11'($urandom_range(0, last + 1));
    r.delta = $urandom;
    pick = $urandom_range(0, 3);
    if (pick == 0) r.pos = $urandom;
    else r.pos = effective($urandom_range(0, last)) + $urandom_range(0, 2) - 1;
    pick = $urandom_range(0, 99);
    if (pick < 12) r.op = OP_READ;
    else if (pick < 22) r.op = OP_WRITE;
    else if (pick < 40) r.op = OP_FIND;
    else if (pick < 56) r.op = OP_CHK;
    else if (pick < 72) r.op = OP_REF;
    else if (pick < 80) r.op = OP_ADJ_ALL;
    else if (pick < 90) r.op = OP_ADJ_LIM;
    else r.op = OP_SET;
    if ($urandom_range(0, 9) == 0) r.idx = 11'($urandom);
    case (r.op)
      OP_READ: begin
        if (r.idx < DEPTH && !shadow_written[r.idx]) r.idx = 11'(DEPTH) | 11'($urandom);
      end
      OP_FIND, OP_CHK, OP_REF: begin
        if (!all_written(0, last)) r.op = OP_SET;
      end
      OP_ADJ_ALL: begin
        if (shadow_offset != 0 && !all_written(shadow_start, last)) r.op = OP_SET;
      end
      OP_ADJ_LIM: begin
        end_at = (r.idx < DEPTH) ? r.idx : DEPTH;
        if (shadow_offset != 0 && end_at > shadow_start &&
            !all_written(shadow_start, end_at - 1)) r.op = OP_SET;
      end
      OP_SET: begin
        case ($urandom_range(0, 3))
          0: r.delta = '0;
          1: r.delta = $urandom_range(0, 20) - 10;
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result side: stalls at random, then checks each response against the
  // oldest answer still due.
  initial begin
    int unsigned stall;
    answer_t want;
    out_rsp.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (!out_rsp.valid);
      if (answers_due.size() == 0) begin
        report("unexpected response", out_rsp.position_out, 32'd0);
      end else begin
        want = answers_due.pop_front();
        if (out_rsp.found_index !== want.found)
          report("found_index", 32'(signed'(out_rsp.found_index)), 32'(signed'(want.found)));
        if (out_rsp.position_out !== want.pos)
          report("position_out", out_rsp.position_out, want.pos);
      end
    end
  end

  // Directed rows, run with last_index 0 right after reset: writes and reads
  // at the extreme positions, accesses past the end of the table, a checked
  // find that must miss, both bounds of the reference find, wrapping offset
  // sums, an adjust that clears at last_index+1, an adjust with no offset and
  // an offset starting above the only entry.
  directed_row_t directed[24];
  initial begin
    directed = '{
      '{OP_WRITE,   11'd0,    POS_MIN, 32'd0,   1, 12'd0,     32'd0},
      '{OP_READ,    11'd0,    32'd0,   32'd0,   1, 12'd0,     POS_MIN},
      '{OP_READ,    11'd1024, 32'd0,   32'd0,   1, 12'd0,     32'd0},
      '{OP_WRITE,   11'd2047, POS_MAX, 32'd0,   1, 12'd0,     32'd0},
      '{OP_READ,    11'd2047, 32'd0,   32'd0,   1, 12'd0,     32'd0},
      '{OP_FIND,    11'd0,    POS_MAX, 32'd0,   1, 12'd0,     32'd0},
      '{OP_CHK,     11'd0,    32'd0,   32'd0,   1, NOT_FOUND, 32'd0},
      '{OP_REF,     11'd0,    POS_MIN, 32'd0,   1, 12'd0,     32'd0},
      '{OP_REF,     11'd0,    POS_MAX, 32'd0,   1, NOT_FOUND, 32'd0},
      '{OP_SET,     11'd0,    32'd0,   POS_MAX, 1, 12'd0,     32'd0},
      '{OP_READ,    11'd0,    32'd0,   32'd0,   1, 12'd0,     32'hffff_ffff},
      '{OP_ADJ_LIM, 11'd1,    32'd0,   32'd0,   1, 12'd0,     32'd0},
      '{OP_READ,    11'd0,    32'd0,   32'd0,   1, 12'd0,     32'hffff_ffff},
      '{OP_SET,     11'd0,    32'd0,   32'd5,   1, 12'd0,     32'd0},
      '{OP_ADJ_ALL, 11'd0,    32'd0,   32'd0,   1, 12'd0,     32'd0},
      '{OP_READ,    11'd0,    32'd0,   32'd0,   1, 12'd0,     32'd4},
      '{OP_ADJ_LIM, 11'd0,    32'd0,   32'd0,   1, 12'd0,     32'd0},
      '{OP_WRITE,   11'd0,    POS_MAX, 32'd0,   1, 12'd0,     32'd0},
      '{OP_READ,    11'd0,    32'd0,   32'd0,   1, 12'd0,     POS_MAX},
      '{OP_SET,     11'd1,    32'd0,   32'd1,   1, 12'd0,     32'd0},
      '{OP_WRITE,   11'd1,    32'd5,   32'd0,   0, 12'd0,     32'd0},
      '{OP_READ,    11'd1,    32'd0,   32'd0,   0, 12'd0,     32'd0},
      '{OP_ADJ_ALL, 11'd0,    32'd0,   32'd0,   0, 12'd0,     32'd0},
      '{OP_READ,    11'd1,    32'd0,   32'd0,   0, 12'd0,     32'd0}
    };
  end

  // Main sequence: reset, the directed rows, then phases of random traffic.
  // Each phase sets a table size and the duplicate mode while the block is
  // idle, fills the table and then mixes every operation on it.
  int unsigned phase_last[10] = '{3, 12, 1, 40, 0, 7, 1023, 25, 2, 60};
  initial begin
    request_t r;
    answer_t typed;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LAST_INDEX;
    cfg_wdata <= '0;
    in_req.valid <= 1'b0;
    in_req.opcode <= OP_READ;
    in_req.entry_index <= '0;
    in_req.position <= '0;
    in_req.offset_delta <= '0;
    errors = 0;
    no_idle = 1'b0;
    stimulus_done = 1'b0;
    shadow_offset = '0;
    shadow_start = '0;
    shadow_hint = '0;
    shadow_last = '0;
    shadow_dup = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_pos[i] = '0;
      shadow_written[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      r.op = directed[k].op;
      r.idx = directed[k].idx;
      r.pos = directed[k].pos;
      r.delta = directed[k].delta;
      typed.found = directed[k].found;
      typed.pos = directed[k].pos_out;
      send_request(r, directed[k].known, typed);
    end

    foreach (phase_last[p]) begin
      wait_until_drained();
      write_register(CFG_LAST_INDEX, 10'(phase_last[p]));
      write_register(CFG_ALLOW_DUP, 10'(p % 2));
      no_idle = ($urandom_range(0, 3) == 0);
      fill_table(phase_last[p], 1'(p % 2));
      for (int n = 0; n < 75; n++) begin
        if (n % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_request(random_request(), 1'b0, typed);
      end
    end

    wait_until_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/ptlos_pkg.sv
src/ptlos_if.sv
src/ptlos_mem.sv
src/position_table_lazy_offset_search.sv
tb/sv/position_table_lazy_offset_search_tb.sv
